/* sv/rau_pkg.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation codes and control types.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int NUM_W     = 32;
    localparam int DEN_W     = 31;
    localparam int FUNC_W    = 4;
    localparam int MAG_W     = 64;
    localparam int CNT_W     = 7;

    localparam logic [FUNC_W-1:0] FN_ADD = 4'd0;
    localparam logic [FUNC_W-1:0] FN_SUB = 4'd1;
    localparam logic [FUNC_W-1:0] FN_MUL = 4'd2;
    localparam logic [FUNC_W-1:0] FN_DIV = 4'd3;
    localparam logic [FUNC_W-1:0] FN_EQ  = 4'd4;
    localparam logic [FUNC_W-1:0] FN_NE  = 4'd5;
    localparam logic [FUNC_W-1:0] FN_LT  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_GT  = 4'd7;
    localparam logic [FUNC_W-1:0] FN_LE  = 4'd8;
    localparam logic [FUNC_W-1:0] FN_GE  = 4'd9;
    localparam logic [FUNC_W-1:0] FN_RCP = 4'd10;

    localparam logic [MAG_W-1:0] LIM =
        (64'd1 << (WORD_BITS - 1)) - 64'd1;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [MAG_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quot;
        logic [MAG_W-1:0] rem;
    } t_div_rsp;

endpackage

/* sv/rau_if.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit channels
// Valid/ready interfaces for the operand and result transfers.
// ----------------------------------------------------------------------------
interface rau_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [rau_pkg::FUNC_W-1:0]           func;
    logic signed [rau_pkg::NUM_W-1:0]     a_num;
    logic [rau_pkg::DEN_W-1:0]            a_den;
    logic signed [rau_pkg::NUM_W-1:0]     b_num;
    logic [rau_pkg::DEN_W-1:0]            b_den;
    modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [rau_pkg::NUM_W-1:0] res_num;
    logic [rau_pkg::DEN_W-1:0]        res_den;
    logic                             cmp_true;
    logic                             overflow;
    modport source (output valid, res_num, res_den, cmp_true, overflow, input ready);
    modport sink   (input valid, res_num, res_den, cmp_true, overflow, output ready);
endinterface

/* sv/rau_div.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring radix-2 divider, one quotient bit per cycle over 64 bits.
// ----------------------------------------------------------------------------
module rau_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rau_pkg::t_div_req   i_req,
    output rau_pkg::t_div_rsp   o_rsp
);
    logic                          r_busy, n_busy;
    logic [rau_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [rau_pkg::MAG_W-1:0]     r_q, n_q, r_r, n_r, r_d, n_d;
    logic                          r_done, n_done;
    logic [rau_pkg::MAG_W:0]       w_sh;

    assign w_sh = {r_r, r_q[rau_pkg::MAG_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.dividend;
            n_r    = '0;
            n_d    = i_req.divisor;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_d}) begin
                n_r = rau_pkg::MAG_W'(w_sh - {1'b0, r_d});
                n_q = {r_q[rau_pkg::MAG_W-2:0], 1'b1};
            end else begin
                n_r = w_sh[rau_pkg::MAG_W-1:0];
                n_q = {r_q[rau_pkg::MAG_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == rau_pkg::CNT_W'(rau_pkg::MAG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) && !$past(i_req.start) |-> r_done) else $error("busy fell early");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < rau_pkg::CNT_W'(rau_pkg::MAG_W)) else $error("count range");
endmodule

/* sv/rational_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// An item is accepted only while the block is idle, and ready stays low from
// acceptance until the result transfer. An item with a NaN operand, an
// unused code, a zero divisor, or a reciprocal of zero or of NaN offers its
// result in the cycle after acceptance. A comparison forms its products in
// S_MUL1, compares them in S_MUL2 and then offers its result. Other items
// pass through S_MUL1 and S_MUL2, or only S_MUL2 for the reciprocal. They
// then use the shared 64-bit serial divider. The GCD takes one divider pass
// per Euclid step, the reduction takes two more passes, and the range check
// is made in S_FIN. A result that waits on the receiver holds the block for
// as long as it waits.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MUL1 = 8'b00000010,
        S_MUL2 = 8'b00000100,
        S_GCD  = 8'b00001000,
        S_DIVN = 8'b00010000,
        S_DIVD = 8'b00100000,
        S_FIN  = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    t_state r_st, n_st;
    logic [rau_pkg::FUNC_W-1:0]       r_fn;
    logic signed [rau_pkg::NUM_W-1:0] r_an, r_bn;
    logic [rau_pkg::DEN_W-1:0]        r_ad, r_bd;
    logic signed [63:0]               r_p1, r_p2;
    logic [63:0]                      r_nm, r_dn, r_x, r_y, r_g;
    logic                             r_neg, r_wait;
    logic signed [rau_pkg::NUM_W-1:0] r_rn;
    logic [rau_pkg::DEN_W-1:0]        r_rd;
    logic                             r_ct, r_ov;
    rau_pkg::t_div_req                w_req;
    rau_pkg::t_div_rsp                w_rsp;
    logic signed [63:0]               w_num;
    logic                             w_nan, w_cmp;
    logic [rau_pkg::NUM_W-1:0]        w_amag, w_bmag;

    rau_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign i_in.ready    = (r_st == S_IDLE);
    assign o_out.valid   = (r_st == S_OUT);
    assign o_out.res_num = r_rn;
    assign o_out.res_den = r_rd;
    assign o_out.cmp_true = r_ct;
    assign o_out.overflow = r_ov;

    assign w_nan = (i_in.a_den == '0) || (i_in.b_den == '0);

    assign w_amag = r_an[rau_pkg::NUM_W-1] ? rau_pkg::NUM_W'(-r_an) : rau_pkg::NUM_W'(r_an);
    assign w_bmag = r_bn[rau_pkg::NUM_W-1] ? rau_pkg::NUM_W'(-r_bn) : rau_pkg::NUM_W'(r_bn);

    always_comb begin
        w_num = (r_fn == rau_pkg::FN_SUB) ? r_p1 - r_p2 : r_p1 + r_p2;
        unique case (r_fn)
            rau_pkg::FN_EQ: w_cmp = (r_p1 == r_p2);
            rau_pkg::FN_NE: w_cmp = (r_p1 != r_p2);
            rau_pkg::FN_LT: w_cmp = (r_p1 < r_p2);
            rau_pkg::FN_GT: w_cmp = (r_p1 > r_p2);
            rau_pkg::FN_LE: w_cmp = (r_p1 <= r_p2);
            default:        w_cmp = (r_p1 >= r_p2);
        endcase
    end

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = r_x;
        w_req.divisor  = r_y;
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_in.valid) begin
                if (i_in.func >= rau_pkg::FN_EQ && i_in.func <= rau_pkg::FN_GE) begin
                    n_st = w_nan ? S_OUT : S_MUL1;
                end else if (i_in.func == rau_pkg::FN_RCP) begin
                    n_st = (i_in.a_num == '0 || i_in.a_den == '0) ? S_OUT : S_MUL2;
                end else if (i_in.func > rau_pkg::FN_RCP || w_nan) begin
                    n_st = S_OUT;
                end else if (i_in.func == rau_pkg::FN_DIV && i_in.b_num == '0) begin
                    n_st = S_OUT;
                end else begin
                    n_st = S_MUL1;
                end
            end
            S_MUL1: n_st = S_MUL2;
            S_MUL2: n_st = (r_fn >= rau_pkg::FN_EQ && r_fn <= rau_pkg::FN_GE) ? S_OUT : S_GCD;
            S_GCD: begin
                if (!r_wait) begin
                    if (r_y == '0) n_st = S_DIVN;
                    else w_req.start = 1'b1;
                end
            end
            S_DIVN: begin
                w_req.dividend = r_nm;
                w_req.divisor  = r_g;
                w_req.start    = !r_wait;
                if (r_wait && w_rsp.done) n_st = S_DIVD;
            end
            S_DIVD: begin
                w_req.dividend = r_dn;
                w_req.divisor  = r_g;
                w_req.start    = !r_wait;
                if (r_wait && w_rsp.done) n_st = S_FIN;
            end
            S_FIN: n_st = S_OUT;
            S_OUT: if (o_out.ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_wait <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_req.start) r_wait <= 1'b1;
            else if (w_rsp.done || n_st != r_st) r_wait <= 1'b0;
        end
        unique case (r_st)
            S_IDLE: begin
                r_fn <= i_in.func;
                r_an <= i_in.a_num;
                r_bn <= i_in.b_num;
                r_ad <= i_in.a_den;
                r_bd <= i_in.b_den;
                r_rn <= '0;
                r_rd <= (i_in.func == rau_pkg::FN_RCP && i_in.a_num != '0 &&
                         i_in.a_den == '0) ? rau_pkg::DEN_W'(1) : '0;
                r_ov <= 1'b0;
                r_ct <= (i_in.func == rau_pkg::FN_NE) && w_nan;
            end
            S_MUL1: begin
                if (r_fn == rau_pkg::FN_MUL) r_p1 <= 64'(r_an) * 64'(r_bn);
                else r_p1 <= 64'(r_an) * 64'($signed({1'b0, r_bd}));
                r_p2 <= 64'(r_bn) * 64'($signed({1'b0, r_ad}));
            end
            S_MUL2: begin
                if (r_fn >= rau_pkg::FN_EQ && r_fn <= rau_pkg::FN_GE) begin
                    r_ct <= w_cmp;
                end else if (r_fn == rau_pkg::FN_RCP) begin
                    r_neg <= r_an[rau_pkg::NUM_W-1];
                    r_nm  <= 64'(r_ad);
                    r_dn  <= 64'(w_amag);
                    r_x   <= 64'(r_ad);
                    r_y   <= 64'(w_amag);
                end else if (r_fn == rau_pkg::FN_DIV) begin
                    r_neg <= r_p1[63] != r_bn[rau_pkg::NUM_W-1];
                    r_nm  <= r_p1[63] ? 64'(-r_p1) : r_p1;
                    r_dn  <= 64'(r_ad) * 64'(w_bmag);
                    r_x   <= r_p1[63] ? 64'(-r_p1) : r_p1;
                    r_y   <= 64'(r_ad) * 64'(w_bmag);
                end else begin
                    r_neg <= w_num[63] && r_fn != rau_pkg::FN_MUL || r_fn == rau_pkg::FN_MUL && r_p1[63];
                    r_nm  <= (r_fn == rau_pkg::FN_MUL) ? (r_p1[63] ? 64'(-r_p1) : r_p1)
                                                   : (w_num[63] ? 64'(-w_num) : w_num);
                    r_dn  <= 64'(r_ad) * 64'(r_bd);
                    r_x   <= (r_fn == rau_pkg::FN_MUL) ? (r_p1[63] ? 64'(-r_p1) : r_p1)
                                                   : (w_num[63] ? 64'(-w_num) : w_num);
                    r_y   <= 64'(r_ad) * 64'(r_bd);
                end
            end
            S_GCD: begin
                if (!r_wait && r_y == '0) r_g <= r_x;
                if (r_wait && w_rsp.done) begin
                    r_x <= r_y;
                    r_y <= w_rsp.rem;
                end
            end
            S_DIVN: if (r_wait && w_rsp.done) r_nm <= w_rsp.quot;
            S_DIVD: if (r_wait && w_rsp.done) r_dn <= w_rsp.quot;
            S_FIN: begin
                if (r_nm == '0) begin
                    r_rn <= '0;
                    r_rd <= rau_pkg::DEN_W'(1);
                end else if (r_dn > rau_pkg::LIM ||
                             r_nm > (r_neg ? rau_pkg::LIM + 64'd1 : rau_pkg::LIM)) begin
                    r_ov <= 1'b1;
                end else begin
                    r_rn <= rau_pkg::NUM_W'(r_neg ? -r_nm : r_nm);
                    r_rd <= r_dn[rau_pkg::DEN_W-1:0];
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !o_out.valid || $past(r_st == S_IDLE))
        else $error("accept state");
    a_ov_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |-> o_out.res_den == '0 && o_out.res_num == '0)
        else $error("overflow not nan");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("ready while holding result");
endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Sends fraction operand items through the input channel and checks each
// result transfer against a built-in predictor of the exact arithmetic,
// comparisons and reduction. Both channels idle at random. The receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    localparam longint CYCLE_LIMIT     = 20_000_000;
    localparam int     N_RANDOM        = 730;
    localparam int     FN_FIRST_UNUSED = int'(rau_pkg::FN_RCP) + 1;
    localparam int     FN_LAST_UNUSED  = (1 << rau_pkg::FUNC_W) - 1;

    typedef struct {
        logic [rau_pkg::FUNC_W-1:0]       func;
        logic signed [rau_pkg::NUM_W-1:0] a_num;
        logic [rau_pkg::DEN_W-1:0]        a_den;
        logic signed [rau_pkg::NUM_W-1:0] b_num;
        logic [rau_pkg::DEN_W-1:0]        b_den;
    } t_frac_op;

    typedef struct {
        logic signed [rau_pkg::NUM_W-1:0] num;
        logic [rau_pkg::DEN_W-1:0]        den;
        logic                             cmp;
        logic                             ovf;
    } t_frac_res;

    logic i_clk;
    logic i_rst_n;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_arithmetic_unit_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_frac_op  op_queue[$];
    t_frac_res result_queue[$];
    int        n_errors;
    int        n_sent;
    int        n_checked;
    int        n_overflow;
    int        n_nan;
    longint    cycle_cnt;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic bit [63:0] gcd64(bit [63:0] x, bit [63:0] y);
        bit [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic bit [63:0] abs64(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic t_frac_res nan_res(bit ovf);
        t_frac_res r;
        r.num = '0;
        r.den = '0;
        r.cmp = 1'b0;
        r.ovf = ovf;
        return r;
    endfunction

    function automatic t_frac_res reduce_frac(bit neg, bit [63:0] nmag, bit [63:0] den);
        t_frac_res r;
        bit [63:0] g;
        g    = gcd64(nmag, den);
        nmag = nmag / g;
        den  = den / g;
        if (nmag == 0) begin
            neg = 1'b0;
            den = 64'd1;
        end
        if (den > rau_pkg::LIM ||
            nmag > (neg ? rau_pkg::LIM + 64'd1 : rau_pkg::LIM)) begin
            return nan_res(1'b1);
        end
        r.num = neg ? rau_pkg::NUM_W'(64'd0 - nmag) : rau_pkg::NUM_W'(nmag);
        r.den = rau_pkg::DEN_W'(den);
        r.cmp = 1'b0;
        r.ovf = 1'b0;
        return r;
    endfunction

    function automatic t_frac_res predict_frac(t_frac_op op);
        t_frac_res r;
        longint    an, ad, bn, bd, lhs, rhs, num;
        bit        nan, c;
        an  = longint'(op.a_num);
        bn  = longint'(op.b_num);
        ad  = longint'({33'd0, op.a_den});
        bd  = longint'({33'd0, op.b_den});
        nan = (ad == 0) || (bd == 0);
        lhs = an * bd;
        rhs = bn * ad;
        r   = nan_res(1'b0);
        if (op.func >= rau_pkg::FN_EQ && op.func <= rau_pkg::FN_GE) begin
            if (nan) begin
                c = (op.func == rau_pkg::FN_NE);
            end else begin
                case (op.func)
                    rau_pkg::FN_EQ: c = (lhs == rhs);
                    rau_pkg::FN_NE: c = (lhs != rhs);
                    rau_pkg::FN_LT: c = (lhs < rhs);
                    rau_pkg::FN_GT: c = (lhs > rhs);
                    rau_pkg::FN_LE: c = (lhs <= rhs);
                    default:        c = (lhs >= rhs);
                endcase
            end
            r.cmp = c;
        end else if (op.func == rau_pkg::FN_RCP) begin
            if (an == 0) begin
                r = nan_res(1'b0);
            end else if (ad == 0) begin
                r.den = rau_pkg::DEN_W'(1);
            end else begin
                r = reduce_frac(an < 0, 64'(ad), abs64(an));
            end
        end else if (op.func > rau_pkg::FN_RCP || nan) begin
            r = nan_res(1'b0);
        end else begin
            case (op.func)
                rau_pkg::FN_ADD: r = reduce_frac(lhs + rhs < 0, abs64(lhs + rhs),
                                                 64'(ad) * 64'(bd));
                rau_pkg::FN_SUB: r = reduce_frac(lhs - rhs < 0, abs64(lhs - rhs),
                                                 64'(ad) * 64'(bd));
                rau_pkg::FN_MUL: begin
                    num = an * bn;
                    r = reduce_frac(num < 0, abs64(num), 64'(ad) * 64'(bd));
                end
                default: begin
                    if (bn == 0) begin
                        r = nan_res(1'b0);
                    end else begin
                        r = reduce_frac((lhs < 0) != (bn < 0), abs64(lhs),
                                        64'(ad) * abs64(bn));
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_frac_op make_op(int f, int an, int ad, int bn, int bd);
        t_frac_op op;
        op.func  = rau_pkg::FUNC_W'(f);
        op.a_num = an;
        op.a_den = rau_pkg::DEN_W'(ad);
        op.b_num = bn;
        op.b_den = rau_pkg::DEN_W'(bd);
        return op;
    endfunction

    function automatic logic signed [rau_pkg::NUM_W-1:0] rand_num();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3, 4: return $urandom;
            default: return $signed(32'($urandom_range(0, 200))) - 100;
        endcase
    endfunction

    function automatic logic [rau_pkg::DEN_W-1:0] rand_den();
        case ($urandom_range(0, 11))
            0:          return '0;
            1:          return rau_pkg::DEN_W'(32'h7fff_ffff);
            2, 3, 4:    return rau_pkg::DEN_W'($urandom);
            default:    return rau_pkg::DEN_W'($urandom_range(1, 120));
        endcase
    endfunction

    initial begin
        int f;
        in_ch.valid  = 1'b0;
        in_ch.func   = '0;
        in_ch.a_num  = '0;
        in_ch.a_den  = '0;
        in_ch.b_num  = '0;
        in_ch.b_den  = '0;
        out_ch.ready = 1'b0;

        for (f = int'(rau_pkg::FN_ADD); f <= int'(rau_pkg::FN_RCP); f++) begin
            op_queue.push_back(make_op(f, 3, 4, -5, 6));
        end
        op_queue.push_back(make_op(rau_pkg::FN_ADD, 1, 0, 2, 3));
        op_queue.push_back(make_op(rau_pkg::FN_NE, 1, 0, 1, 0));
        op_queue.push_back(make_op(rau_pkg::FN_EQ, 1, 2, 2, 0));
        op_queue.push_back(make_op(rau_pkg::FN_SUB, 5, 7, 5, 7));
        op_queue.push_back(make_op(rau_pkg::FN_DIV, 5, 7, 0, 3));
        op_queue.push_back(make_op(rau_pkg::FN_RCP, 0, 9, 1, 1));
        op_queue.push_back(make_op(rau_pkg::FN_RCP, -7, 0, 1, 1));
        op_queue.push_back(make_op(rau_pkg::FN_RCP, 0, 0, 1, 1));
        op_queue.push_back(make_op(FN_FIRST_UNUSED, 1, 1, 1, 1));
        op_queue.push_back(make_op(FN_LAST_UNUSED, 1, 1, 1, 1));
        op_queue.push_back(make_op(rau_pkg::FN_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe));
        op_queue.push_back(make_op(rau_pkg::FN_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1));
        op_queue.push_back(make_op(rau_pkg::FN_RCP, 32'h8000_0000, 1, 1, 1));
        op_queue.push_back(make_op(rau_pkg::FN_DIV, 32'h8000_0000, 1, -1, 1));
        op_queue.push_back(make_op(rau_pkg::FN_LT, 32'h7fff_ffff, 32'h7fff_ffff,
                                   32'h8000_0000, 1));

        for (int i = 0; i < N_RANDOM; i++) begin
            t_frac_op op;
            op.func  = ($urandom_range(0, 19) == 0)
                       ? rau_pkg::FUNC_W'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED))
                       : rau_pkg::FUNC_W'($urandom_range(0, int'(rau_pkg::FN_RCP)));
            op.a_num = rand_num();
            op.a_den = rand_den();
            op.b_num = rand_num();
            op.b_den = rand_den();
            op_queue.push_back(op);
        end

        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (op_queue.size() == 0 && result_queue.size() == 0);
        repeat (6000) @(posedge i_clk);
        $display("Covered %0d transfers in, %0d results checked (%0d NaN, %0d overflow).",
                 n_sent, n_checked, n_nan, n_overflow);
        if (n_errors == 0 && result_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Driver: bursts of items separated by random gaps.
    bit took;
    int burst_left = 1;
    int gap_left;

    always @(posedge i_clk) begin
        took = in_ch.valid && in_ch.ready;
        if (took) begin
            result_queue.push_back(predict_frac(op_queue.pop_front()));
            n_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !(in_ch.valid && !took)) begin
            if (gap_left > 0 || op_queue.size() == 0) begin
                if (gap_left > 0) gap_left--;
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.valid <= 1'b1;
                in_ch.func  <= op_queue[0].func;
                in_ch.a_num <= op_queue[0].a_num;
                in_ch.a_den <= op_queue[0].a_den;
                in_ch.b_num <= op_queue[0].b_num;
                in_ch.b_den <= op_queue[0].b_den;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 10);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // Receiver: random stalls in some stretches, one long hold-off.
    int  hold_left;
    bit  hold_done;
    int  mode_cnt;
    bit  stall_mode;

    always @(negedge i_clk) begin
        mode_cnt++;
        if (mode_cnt % 200 == 0) stall_mode = $urandom_range(0, 1);
        if (!hold_done && n_sent >= 300) begin
            hold_done = 1'b1;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // Monitor and checker.
    always @(posedge i_clk) begin
        t_frac_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (result_queue.size() == 0) begin
                $error("result transfer with no expectation waiting");
                n_errors++;
            end else begin
                want = result_queue.pop_front();
                n_checked++;
                if (want.ovf) n_overflow++;
                if (want.den == '0 && !want.ovf) n_nan++;
                if (out_ch.res_num !== want.num) begin
                    $error("res_num expected %0d actual %0d", want.num, out_ch.res_num);
                    n_errors++;
                end
                if (out_ch.res_den !== want.den) begin
                    $error("res_den expected %0d actual %0d", want.den, out_ch.res_den);
                    n_errors++;
                end
                if (out_ch.cmp_true !== want.cmp) begin
                    $error("cmp_true expected %0b actual %0b", want.cmp, out_ch.cmp_true);
                    n_errors++;
                end
                if (out_ch.overflow !== want.ovf) begin
                    $error("overflow expected %0b actual %0b", want.ovf, out_ch.overflow);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_cnt);
            $display("TEST FAILED");
            $finish;
        end
    end
endmodule
